>>> rtl/mpe_pkg.sv
// Shared constants, codes, types and helpers of the matrix product element engine.
package mpe_pkg;

  // Store geometry: both matrices are row-major with a fixed row stride.
  localparam int MAX_DIM = 32;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W   = $clog2(MAX_DIM + 1);
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Field widths.
  localparam int OP_W   = 2;
  localparam int POS_W  = 5;
  localparam int ELEM_W = 32;
  localparam int STAT_W = 2;
  localparam int REG_W  = 6;
  localparam int RIDX_W = 2;

  // Arithmetic widths: exact Q32.32 products and a sum that cannot overflow.
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = PROD_W + CNT_W;
  localparam int FRAC_W = 16;

  // Operation codes. The last code has no operation and the block drops it.
  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_SIZE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  // Configuration register indexes.
  localparam logic [RIDX_W-1:0] REG_A_ROWS = 2'd0;
  localparam logic [RIDX_W-1:0] REG_A_COLS = 2'd1;
  localparam logic [RIDX_W-1:0] REG_B_ROWS = 2'd2;
  localparam logic [RIDX_W-1:0] REG_B_COLS = 2'd3;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT,
    S_EMIT
  } state_t;

  // Control that travels alongside the operand data into the MAC pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

  // Flat store address of element (r, c).
  function automatic logic [ADDR_W-1:0] elem_addr(input int unsigned r, input int unsigned c);
    int unsigned a;
    a = r * MAX_DIM + c;
    return a[ADDR_W-1:0];
  endfunction

  // Counts above the store size act as the store size.
  function automatic logic [CNT_W-1:0] clamp_dim(input logic [REG_W-1:0] v);
    int unsigned x;
    x = (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
    return x[CNT_W-1:0];
  endfunction

endpackage

>>> rtl/matrix_product_element_engine_top.sv
// Top level of the matrix product element engine: sequencer, element stores and MAC.
//
// Usage: items arrive on the input channel (in_valid/in_ready) with an operation,
// a row, a column and an element value. Operation 0 writes the value into the
// A store, operation 1 into the B store; neither gives a result and the next
// item is taken in the following cycle. Operation 2 asks for element
// (row, column) of A times B; its one result (product_value, status) leaves
// on the output channel (out_valid/out_ready). Operation 3 is dropped.
// A query with mismatched inner dimensions or coordinates outside the product
// answers without running the MAC. A valid query walks the inner index over the
// clamped A column count, through the store reads and the MAC stages; the MAC
// performs one multiply-accumulate per cycle, limited by one read port per store.
// The block takes one query at a time; in_ready is low until its result has
// been placed in the output register.
// Reset clears the control state and sets all four counts to 1; the stores
// keep their contents and must be written before they are read.
// A stalled receiver holds the result in the output register; the block still
// accepts loads meanwhile, and a further query waits only at its own end.
// The user writes counts (cfg_wr_en/cfg_index/cfg_data) only while idle; not enforced.
module matrix_product_element_engine_top import mpe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [RIDX_W-1:0]        cfg_index,
  input  logic [REG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OP_W-1:0]          operation,
  input  logic [POS_W-1:0]         row_index,
  input  logic [POS_W-1:0]         col_index,
  input  logic signed [ELEM_W-1:0] element_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [ELEM_W-1:0] product_value,
  output logic [STAT_W-1:0]        status
);

  state_t                   state;
  state_t                   state_next;
  logic [REG_W-1:0]         a_row_count;
  logic [REG_W-1:0]         a_col_count;
  logic [REG_W-1:0]         b_row_count;
  logic [REG_W-1:0]         b_col_count;
  logic [DIM_W-1:0]         k;
  logic [CNT_W-1:0]         inner;
  logic [POS_W-1:0]         row_q;
  logic [POS_W-1:0]         col_q;
  logic signed [ELEM_W-1:0] pend_value;
  logic [STAT_W-1:0]        pend_status;
  mac_ctl_t                 rd_ctl;
  mac_ctl_t                 rd_ctl_q;
  logic                     accept;
  logic                     in_store;
  logic                     a_we;
  logic                     b_we;
  logic [ADDR_W-1:0]        wr_addr;
  logic [ADDR_W-1:0]        a_rd_addr;
  logic [ADDR_W-1:0]        b_rd_addr;
  logic [ELEM_W-1:0]        a_rd_data;
  logic [ELEM_W-1:0]        b_rd_data;
  logic                     res_valid;
  logic signed [ELEM_W-1:0] res_value;
  logic                     size_err;
  logic                     range_err;
  logic                     k_last;
  logic                     out_load;

  // Input handshake and load decoding.
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_store = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
  assign a_we     = accept && (operation == OP_LOAD_A) && in_store;
  assign b_we     = accept && (operation == OP_LOAD_B) && in_store;
  assign wr_addr  = elem_addr(int'(row_index), int'(col_index));

  // Query checks against the configured counts.
  assign size_err  = (a_col_count != b_row_count);
  assign range_err = (int'(row_index) >= int'(clamp_dim(a_row_count))) ||
                     (int'(col_index) >= int'(clamp_dim(b_col_count)));

  // Row of A and column of B walked by the inner index.
  assign a_rd_addr = elem_addr(int'(row_q), int'(k));
  assign b_rd_addr = elem_addr(int'(k), int'(col_q));
  assign k_last    = (CNT_W'(k) + CNT_W'(1)) == inner;

  assign out_load = (state == S_EMIT) && (!out_valid || out_ready);

  // Next state and read control.
  always_comb begin
    state_next = state;
    rd_ctl     = '0;
    case (state)
      S_IDLE: begin
        if (accept && (operation == OP_QUERY)) begin
          if (size_err || range_err || (clamp_dim(a_col_count) == '0)) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_RUN;
          end
        end
      end
      S_RUN: begin
        rd_ctl.valid = 1'b1;
        rd_ctl.first = (k == '0);
        rd_ctl.last  = k_last;
        if (k_last) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (res_valid) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rd_ctl_q    <= '0;
      out_valid   <= 1'b0;
      a_row_count <= REG_W'(1);
      a_col_count <= REG_W'(1);
      b_row_count <= REG_W'(1);
      b_col_count <= REG_W'(1);
    end else begin
      state    <= state_next;
      rd_ctl_q <= rd_ctl;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_A_ROWS: a_row_count <= cfg_data;
          REG_A_COLS: a_col_count <= cfg_data;
          REG_B_ROWS: b_row_count <= cfg_data;
          REG_B_COLS: b_col_count <= cfg_data;
          default:    a_row_count <= a_row_count;
        endcase
      end
    end
  end

  // Query context, inner index and pending result.
  always_ff @(posedge clk) begin
    if (accept && (operation == OP_QUERY)) begin
      row_q      <= row_index;
      col_q      <= col_index;
      inner      <= clamp_dim(a_col_count);
      k          <= '0;
      pend_value <= '0;
      if (size_err) begin
        pend_status <= ST_SIZE;
      end else if (range_err) begin
        pend_status <= ST_RANGE;
      end else begin
        pend_status <= ST_OK;
      end
    end else if (state == S_RUN) begin
      k <= k + DIM_W'(1);
    end else if ((state == S_WAIT) && res_valid) begin
      pend_value <= res_value;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      product_value <= pend_value;
      status        <= pend_status;
    end
  end

  mpe_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_a_store (
    .clk     (clk),
    .wr_en   (a_we),
    .wr_addr (wr_addr),
    .wr_data (element_value),
    .rd_addr (a_rd_addr),
    .rd_data (a_rd_data)
  );

  mpe_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_b_store (
    .clk     (clk),
    .wr_en   (b_we),
    .wr_addr (wr_addr),
    .wr_data (element_value),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd_data)
  );

  mpe_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rd_ctl_q),
    .a_data    (a_rd_data),
    .b_data    (b_rd_data),
    .res_valid (res_valid),
    .res_value (res_value)
  );

endmodule

>>> rtl/mpe_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module mpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/mpe_mac.sv
// Multiply-accumulate pipeline with Q16.16 truncation and saturation of the sum.
module mpe_mac import mpe_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctl_t                 ctl,
  input  logic signed [ELEM_W-1:0] a_data,
  input  logic signed [ELEM_W-1:0] b_data,
  output logic                     res_valid,
  output logic signed [ELEM_W-1:0] res_value
);

  mac_ctl_t                   prod_ctl;
  mac_ctl_t                   acc_ctl;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ELEM_W-1:0]   sat_value;
  logic                       fits;

  // Control travels with the data through the product and sum stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctl  <= '0;
      acc_ctl   <= '0;
      res_valid <= 1'b0;
    end else begin
      prod_ctl  <= ctl;
      acc_ctl   <= prod_ctl;
      res_valid <= acc_ctl.valid && acc_ctl.last;
    end
  end

  // Product stage: one exact 32 by 32 signed multiply per cycle.
  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      prod <= a_data * b_data;
    end
  end

  assign prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};

  // Sum stage: the first term of a dot product restarts the sum.
  always_ff @(posedge clk) begin
    if (prod_ctl.valid) begin
      acc <= prod_ctl.first ? prod_ext : acc + prod_ext;
    end
  end

  // The truncated sum fits when its top bit and every bit above it match the sign.
  always_comb begin
    fits = (&acc[ACC_W-1:FRAC_W+ELEM_W-1]) || !(|acc[ACC_W-1:FRAC_W+ELEM_W-1]);
    if (fits) begin
      sat_value = acc[FRAC_W+ELEM_W-1:FRAC_W];
    end else if (acc[ACC_W-1]) begin
      sat_value = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(ELEM_W-1){1'b1}}};
    end
  end

  // Result stage holds the value until the next dot product ends.
  always_ff @(posedge clk) begin
    if (acc_ctl.valid && acc_ctl.last) begin
      res_value <= sat_value;
    end
  end

endmodule

>>> rtl/mpe_checker.sv
// Port-level checker of the matrix product element engine, bound to the top level.
module mpe_checker import mpe_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     cfg_wr_en,
  input logic [RIDX_W-1:0]        cfg_index,
  input logic [REG_W-1:0]         cfg_data,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [OP_W-1:0]          operation,
  input logic [POS_W-1:0]         row_index,
  input logic [POS_W-1:0]         col_index,
  input logic signed [ELEM_W-1:0] element_value,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [ELEM_W-1:0] product_value,
  input logic [STAT_W-1:0]        status
);

  // A stalled result holds still.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(product_value) && $stable(status))
    else $error("stalled result changed");

  // Any error status comes with a zero product.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> product_value == '0)
    else $error("error result carries a nonzero product");

  // An accepted query takes in_ready low, blocking further input.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == OP_QUERY) |=> !in_ready)
    else $error("input taken while a query is in progress");

  // A load leaves the block ready for the next item.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && ((operation == OP_LOAD_A) || (operation == OP_LOAD_B))
    |=> in_ready)
    else $error("load stalled the input");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind matrix_product_element_engine_top mpe_checker u_mpe_checker (.*);

>>> tb/tb_matrix_product_element_engine_top.sv
// Self-checking testbench for the matrix product element engine top level.
module tb_matrix_product_element_engine_top;
  import mpe_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DRAIN_CYCLES = MAX_DIM + 8;
  localparam int          FRAC_BITS    = 16;
  localparam int          SUM_BITS     = 2 * ELEM_W + 16;
  localparam int unsigned BLOCK_STEPS  = 24;

  // One product element as it leaves the block.
  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic [STAT_W-1:0] code;
  } product_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [RIDX_W-1:0]        cfg_index = '0;
  logic [REG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [OP_W-1:0]          operation = '0;
  logic [POS_W-1:0]         row_index = '0;
  logic [POS_W-1:0]         col_index = '0;
  logic signed [ELEM_W-1:0] element_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [ELEM_W-1:0] product_value;
  logic [STAT_W-1:0]        status;

  // Local copy of the element stores, the counts and the expected products.
  logic [ELEM_W-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic [ELEM_W-1:0] b_mem [MAX_DIM*MAX_DIM];
  bit                a_written [MAX_DIM*MAX_DIM];
  bit                b_written [MAX_DIM*MAX_DIM];
  logic [REG_W-1:0]  dims [4] = '{default: 6'd1};
  product_t          pending_products [$];
  product_t          oldest_product;

  int unsigned send_gap_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned items_accepted = 0;
  int unsigned error_count = 0;
  int unsigned cycles_run = 0;

  matrix_product_element_engine_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .row_index    (row_index),
    .col_index    (col_index),
    .element_value(element_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .product_value(product_value),
    .status       (status)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Counts above the store size act as the store size.
  function automatic int unsigned used_dim(input logic [REG_W-1:0] v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

  // Element values: extremes, small values that keep sums in range, and wide noise.
  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom_range(32'h3_FFFF) - 32'h2_0000;
      default: return $urandom();
    endcase
  endfunction

  // Applies one accepted item to the local stores and queues its product, if any.
  function automatic void predict_product(input logic [OP_W-1:0] op,
                                          input logic [POS_W-1:0] row,
                                          input logic [POS_W-1:0] col,
                                          input logic [ELEM_W-1:0] val);
    product_t                   answer;
    logic signed [SUM_BITS-1:0] sum;
    logic signed [SUM_BITS-1:0] floor_q;
    logic signed [2*ELEM_W-1:0] term;
    int unsigned                inner;
    answer = '{value: '0, code: ST_OK};
    sum = '0;
    inner = used_dim(dims[REG_A_COLS]);
    items_accepted++;
    case (op)
      OP_LOAD_A: begin
        a_mem[row * MAX_DIM + col] = val;
        a_written[row * MAX_DIM + col] = 1'b1;
      end
      OP_LOAD_B: begin
        b_mem[row * MAX_DIM + col] = val;
        b_written[row * MAX_DIM + col] = 1'b1;
      end
      OP_QUERY: begin
        // The size check compares raw counts and takes precedence.
        if (dims[REG_A_COLS] != dims[REG_B_ROWS]) begin
          answer.code = ST_SIZE;
        end else if (row >= used_dim(dims[REG_A_ROWS]) ||
                     col >= used_dim(dims[REG_B_COLS])) begin
          answer.code = ST_RANGE;
        end else begin
          for (int k = 0; k < inner; k++) begin
            term = $signed(a_mem[row * MAX_DIM + k]) * $signed(b_mem[k * MAX_DIM + col]);
            sum = sum + term;
          end
          // Floor to Q16.16, then saturate to 32 bits.
          floor_q = sum >>> FRAC_BITS;
          if (floor_q[SUM_BITS-1:ELEM_W-1] == '0 || floor_q[SUM_BITS-1:ELEM_W-1] == '1) begin
            answer.value = floor_q[ELEM_W-1:0];
          end else begin
            answer.value = floor_q[SUM_BITS-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end
        end
        pending_products.push_back(answer);
      end
      default: ;
    endcase
  endfunction

  // Sends one item; valid stays high into the next item unless the sender idles.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] row,
                           input logic [POS_W-1:0] col, input logic [ELEM_W-1:0] val);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    row_index     <= row;
    col_index     <= col;
    element_value <= val;
    do @(posedge clk); while (!in_ready);
    predict_product(op, row, col, val);
  endtask

  // Lowers valid and waits until every product has come back and the block is quiet.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drives one register write; the caller lowers the write enable.
  task automatic write_reg(input logic [RIDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    dims[idx] = val;
    @(posedge clk);
  endtask

  // Writes all four counts while the block is idle.
  task automatic set_dims(input logic [REG_W-1:0] a_rows, input logic [REG_W-1:0] a_cols,
                          input logic [REG_W-1:0] b_rows, input logic [REG_W-1:0] b_cols);
    drain_results();
    write_reg(REG_A_ROWS, a_rows);
    write_reg(REG_A_COLS, a_cols);
    write_reg(REG_B_ROWS, b_rows);
    write_reg(REG_B_COLS, b_cols);
    cfg_wr_en <= 1'b0;
  endtask

  // Queries one product element, first loading any store entry it would read unwritten.
  task automatic query_element(input logic [POS_W-1:0] row, input logic [POS_W-1:0] col);
    if (dims[REG_A_COLS] == dims[REG_B_ROWS] && row < used_dim(dims[REG_A_ROWS]) &&
        col < used_dim(dims[REG_B_COLS])) begin
      for (int k = 0; k < used_dim(dims[REG_A_COLS]); k++) begin
        if (!a_written[row * MAX_DIM + k]) send_item(OP_LOAD_A, row, POS_W'(k), rand_elem());
        if (!b_written[k * MAX_DIM + col]) send_item(OP_LOAD_B, POS_W'(k), col, rand_elem());
      end
    end
    send_item(OP_QUERY, row, col, $urandom());
  endtask

  // Counts after reset are all one.
  task automatic test_reset_counts();
    send_item(OP_LOAD_A, 5'd0, 5'd0, 32'h0001_8000);
    send_item(OP_LOAD_B, 5'd0, 5'd0, 32'hFFFF_0000);
    query_element(5'd0, 5'd0);
    query_element(5'd0, 5'd1);
    query_element(5'd1, 5'd0);
  endtask

  // Saturation both ways, floor rounding of a tiny negative product, ignored operation.
  task automatic test_value_extremes();
    send_item(OP_LOAD_A, 5'd0, 5'd0, 32'h7FFF_FFFF);
    send_item(OP_LOAD_B, 5'd0, 5'd0, 32'h7FFF_FFFF);
    query_element(5'd0, 5'd0);
    send_item(OP_LOAD_B, 5'd0, 5'd0, 32'h8000_0000);
    query_element(5'd0, 5'd0);
    send_item(OP_LOAD_A, 5'd0, 5'd0, 32'h8000_0000);
    query_element(5'd0, 5'd0);
    send_item(OP_LOAD_A, 5'd0, 5'd0, 32'h0000_0001);
    send_item(OP_LOAD_B, 5'd0, 5'd0, 32'hFFFF_FFFF);
    query_element(5'd0, 5'd0);
    // The unused operation code must neither load nor answer.
    send_item(OP_UNUSED, 5'd0, 5'd0, 32'h1234_5678);
    query_element(5'd0, 5'd0);
  endtask

  // Inner sizes that differ give the size error, even when the clamped sizes agree.
  task automatic test_size_mismatch();
    set_dims(6'd1, 6'd2, 6'd3, 6'd1);
    query_element(5'd31, 5'd31);
    set_dims(6'd1, 6'd32, 6'd40, 6'd1);
    query_element(5'd0, 5'd0);
  endtask

  // Zero counts and counts above the store size.
  task automatic test_zero_and_clamp();
    set_dims(6'd0, 6'd1, 6'd1, 6'd1);
    query_element(5'd0, 5'd0);
    set_dims(6'd1, 6'd0, 6'd0, 6'd1);
    query_element(5'd0, 5'd0);
    set_dims(6'd63, 6'd1, 6'd1, 6'd63);
    query_element(5'd31, 5'd31);
  endtask

  // Picks counts for one block of random traffic: mostly small, a few large or odd.
  task automatic pick_random_dims();
    logic [REG_W-1:0] inner;
    case ($urandom_range(9))
      0: begin
        inner = REG_W'($urandom_range(63));
        set_dims(REG_W'($urandom_range(63)), inner, inner + REG_W'($urandom_range(1, 63)),
                 REG_W'($urandom_range(63)));
      end
      1: begin
        inner = REG_W'($urandom_range(28, 63));
        set_dims(REG_W'($urandom_range(28, 63)), inner, inner,
                 REG_W'($urandom_range(28, 63)));
      end
      2: begin
        inner = REG_W'($urandom_range(2));
        set_dims(REG_W'($urandom_range(2)), inner, inner, REG_W'($urandom_range(2)));
      end
      default: begin
        inner = REG_W'($urandom_range(1, 4));
        set_dims(REG_W'($urandom_range(1, 4)), inner, inner, REG_W'($urandom_range(1, 4)));
      end
    endcase
  endtask

  // One step of random traffic: mostly in-range queries, some reloads and noise.
  task automatic random_step();
    int unsigned rows;
    int unsigned cols;
    int unsigned pick;
    rows = used_dim(dims[REG_A_ROWS]);
    cols = used_dim(dims[REG_B_COLS]);
    pick = $urandom_range(99);
    if (pick < 55 && rows != 0 && cols != 0) begin
      query_element(POS_W'($urandom_range(rows - 1)), POS_W'($urandom_range(cols - 1)));
    end else if (pick < 70) begin
      query_element(POS_W'($urandom_range(31)), POS_W'($urandom_range(31)));
    end else if (pick < 95) begin
      send_item($urandom_range(1) ? OP_LOAD_B : OP_LOAD_A, POS_W'($urandom_range(31)),
                POS_W'($urandom_range(31)), rand_elem());
    end else begin
      send_item(OP_UNUSED, POS_W'($urandom_range(31)), POS_W'($urandom_range(31)),
                $urandom());
    end
  endtask

  // Random traffic under one idling pattern until the item quota is used up.
  task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned stall_pct,
                                     input int unsigned quota);
    int unsigned start;
    drain_results();
    send_gap_pct = gap_pct;
    sink_stall_pct = stall_pct;
    start = items_accepted;
    while (items_accepted - start < quota) begin
      pick_random_dims();
      for (int step = 0; step < BLOCK_STEPS && items_accepted - start < quota; step++) begin
        random_step();
      end
    end
  endtask

  // Compares each product that leaves the block with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_products.size() == 0) begin
        $display("%0t: unexpected item, value %h status %0d", $time, product_value, status);
        error_count++;
      end else begin
        oldest_product = pending_products.pop_front();
        if (product_value !== oldest_product.value) begin
          $display("%0t: product_value expected %h actual %h", $time,
                   oldest_product.value, product_value);
          error_count++;
        end
        if (status !== oldest_product.code) begin
          $display("%0t: status expected %0d actual %0d", $time, oldest_product.code, status);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Test sequence.
  initial begin
    send_gap_pct = 27;
    sink_stall_pct = 81;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_counts();
    test_value_extremes();
    test_size_mismatch();
    test_zero_and_clamp();
    test_random_traffic(27, 81, 170);
    test_random_traffic(81, 27, 170);
    test_random_traffic(0, 0, 170);
    drain_results();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/mpe_pkg.sv
rtl/mpe_ram.sv
rtl/mpe_mac.sv
rtl/matrix_product_element_engine_top.sv
rtl/mpe_checker.sv
tb/tb_matrix_product_element_engine_top.sv
